>>> sv/loh_pkg.sv
package loh_pkg;

    localparam int CNT_W     = 13;
    localparam int REL_W     = 12;
    localparam int CONF_W    = 8;
    localparam int MAG_W     = 21;
    localparam int GAIN_W    = 16;
    localparam int ALPHA_W   = 17;
    localparam int SPD_W     = 16;
    localparam int OFS_W     = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 21;

    // serial multiplier: signed multiplicand, unsigned multiplier scanned one bit a cycle
    localparam int MUL_A_W   = 23;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam int IDLE_LSB  = 65;
    localparam int LOCK_LSB  = 13108;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam logic [CONF_W-1:0]  STREAK_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EALPHA  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RALPHA  = 3'd7;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [CONF_W-1:0] streak;
        logic              releasing;
    } t_side_st;

    typedef struct packed {
        logic [CNT_W-1:0]        center;
        logic [CNT_W-1:0]        left;
        logic [CNT_W-1:0]        right;
        logic [MAG_W-1:0]        mag;
        logic [CNT_W-1:0]        trig;
        logic [REL_W-1:0]        rel;
        logic [CONF_W-1:0]       confirm;
        logic signed [OFS_W-1:0] offset;
    } t_side_in;

endpackage

>>> sv/lateral_offset_hysteresis_guide.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  voxel counts and speed
// m_axis    out        m_axis_tvalid / m_axis_tready  offset, target, status
// cfg       in         i_cfg_valid / o_cfg_ready      register index and data
//
// Each item runs from acceptance to its result through two passes of the 17-step
// bit-serial multiplier (gain times speed, then alpha times the offset error), a
// registered done flag after each pass, the side decision and the final round.
// The next item is accepted in the cycle the result appears; items are taken one
// at a time, so a new item waits until the last result is registered, which a
// stalled output side delays.
// Reset (synchronous, active low) restores register defaults and clears the offset
// and side state. A stalled result holds the final stage until taken.
module lateral_offset_hysteresis_guide #(
    parameter int MAX_VOXELS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis_tdata: centre_count[12:0], left_count[25:13], right_count[38:26],
    //               speed[54:39], zero fill[55]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [55:0]                       s_axis_tdata,
    // m_axis_tdata: offset_now[21:0], target_now[43:22], active[44],
    //               streak_out[52:45], side_out[54:53], zero fill[55]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [55:0]                       m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [loh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [loh_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import loh_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_SIDE = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [CNT_W-1:0]   r_trigger;
    logic [REL_W-1:0]   r_release;
    logic [CONF_W-1:0]  r_confirm;
    logic [MAG_W-1:0]   r_min, r_max;
    logic [GAIN_W-1:0]  r_gain;
    logic [ALPHA_W-1:0] r_ealpha, r_ralpha;

    // per-item working registers
    logic [CNT_W-1:0]        r_center, r_left, r_right;
    logic [SPD_W-2:0]        r_spd;
    logic [MAG_W-1:0]        r_mag, n_mag;
    logic signed [OFS_W-1:0] r_target;

    // persistent state
    logic signed [OFS_W-1:0] r_offset;
    t_side_st                r_side_st, w_side_st;

    logic        r_ovalid;
    logic [55:0] r_odata;

    logic                      w_accept, w_fin_go;
    logic                      mul_start, mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    t_side_in                w_side_in;
    logic signed [OFS_W-1:0] w_target;
    logic [ALPHA_W-1:0]      w_alpha;
    logic [MUL_P_W-2:0]      w_raw;
    logic [MUL_P_W-2:0]      w_raw_lo;

    logic signed [MUL_P_W-1:0] w_prod_rnd;
    logic signed [OFS_W+1:0]   w_q, w_off, w_maxs, w_offc;
    logic                      w_snap;
    logic signed [OFS_W-1:0]   w_off_fin;
    t_side_st                  w_st_fin;
    logic                      w_active;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        return (32'(c) > MAX_VOXELS) ? CNT_W'(MAX_VOXELS) : c;
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fin_go      = (r_state == ST_FIN) && (!r_ovalid || m_axis_tready);

    // configuration writes; always accepted and applied at the next edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger <= 13'd3;
            r_release <= 12'd1;
            r_confirm <= 8'd3;
            r_min     <= 21'd0;
            r_max     <= 21'd65536;
            r_gain    <= 16'd256;
            r_ealpha  <= 17'd19661;
            r_ralpha  <= 17'd13107;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TRIGGER: r_trigger <= i_cfg_data[CNT_W-1:0];
                REG_RELEASE: r_release <= i_cfg_data[REL_W-1:0];
                REG_CONFIRM: r_confirm <= i_cfg_data[CONF_W-1:0];
                REG_MIN:     r_min     <= i_cfg_data[MAG_W-1:0];
                REG_MAX:     r_max     <= i_cfg_data[MAG_W-1:0];
                REG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_EALPHA:  r_ealpha  <= ALPHA_W'(i_cfg_data);
                REG_RALPHA:  r_ralpha  <= ALPHA_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // multiplier operands: gain times speed on acceptance, alpha times error in SIDE
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        if (w_accept) begin
            mul_start = 1'b1;
            mul_a     = $signed(MUL_A_W'(s_axis_tdata[54] ? 15'd0 : s_axis_tdata[53:39]));
            mul_b     = MUL_B_W'(r_gain);
        end else if (r_state == ST_SIDE) begin
            mul_start = 1'b1;
            mul_a     = MUL_A_W'(w_target) - MUL_A_W'(r_offset);
            mul_b     = w_alpha;
        end
    end

    loh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // clamp the raw magnitude to min first, then max; a zero max yields zero
    assign w_raw    = mul_prod[MUL_P_W-2:0];
    assign w_raw_lo = (w_raw < (MUL_P_W-1)'(r_min)) ? (MUL_P_W-1)'(r_min) : w_raw;
    assign n_mag    = (w_raw_lo > (MUL_P_W-1)'(r_max)) ? r_max : w_raw_lo[MAG_W-1:0];

    assign w_side_in.center  = r_center;
    assign w_side_in.left    = r_left;
    assign w_side_in.right   = r_right;
    assign w_side_in.mag     = r_mag;
    assign w_side_in.trig    = (r_trigger == '0) ? CNT_W'(1) : r_trigger;
    assign w_side_in.rel     = r_release;
    assign w_side_in.confirm = r_confirm;
    assign w_side_in.offset  = r_offset;

    loh_side u_side (
        .i_in     (w_side_in),
        .i_st     (r_side_st),
        .o_st     (w_side_st),
        .o_target (w_target)
    );

    // pick the smoothing weight and saturate it to one
    always_comb begin
        w_alpha = (w_target != '0) ? r_ealpha : r_ralpha;
        if (w_alpha > ALPHA_ONE) begin
            w_alpha = ALPHA_ONE;
        end
    end

    // round to nearest (ties up), step the offset, clamp to +-max and snap when idle
    assign w_prod_rnd = mul_prod + MUL_P_W'(32768);
    assign w_q        = $signed(w_prod_rnd[MUL_P_W-1:16]);
    assign w_off      = {{2{r_offset[OFS_W-1]}}, r_offset} + w_q;
    assign w_maxs     = $signed({3'b000, r_max});

    always_comb begin
        if (w_off > w_maxs) begin
            w_offc = w_maxs;
        end else if (w_off < -w_maxs) begin
            w_offc = -w_maxs;
        end else begin
            w_offc = w_off;
        end
        w_snap = (r_target == '0) && (w_offc <= (OFS_W+2)'(IDLE_LSB))
                 && (w_offc >= -(OFS_W+2)'(IDLE_LSB));
        if (w_snap) begin
            w_off_fin = '0;
            w_st_fin  = '{side: SIDE_NONE, streak: '0, releasing: 1'b0};
        end else begin
            w_off_fin = w_offc[OFS_W-1:0];
            w_st_fin  = r_side_st;
        end
        w_active = (w_off_fin > OFS_W'(IDLE_LSB)) || (w_off_fin < -OFS_W'(IDLE_LSB));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_MUL1;
            ST_MUL1: if (mul_done) n_state = ST_SIDE;
            ST_SIDE: n_state = ST_MUL2;
            ST_MUL2: if (mul_done) n_state = ST_FIN;
            ST_FIN:  if (w_fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_offset  <= '0;
            r_side_st <= '{side: SIDE_NONE, streak: '0, releasing: 1'b0};
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SIDE) begin
                r_side_st <= w_side_st;
            end
            if (w_fin_go) begin
                r_offset  <= w_off_fin;
                r_side_st <= w_st_fin;
                r_ovalid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers: latch the item, the magnitude, the target and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_center <= sat_count(s_axis_tdata[12:0]);
            r_left   <= sat_count(s_axis_tdata[25:13]);
            r_right  <= sat_count(s_axis_tdata[38:26]);
        end
        if ((r_state == ST_MUL1) && mul_done) begin
            r_mag <= n_mag;
        end
        if (r_state == ST_SIDE) begin
            r_target <= w_target;
        end
        if (w_fin_go) begin
            r_odata <= {1'b0, w_st_fin.side, w_st_fin.streak, w_active, r_target, w_off_fin};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // spare signal: speed sign is folded into the multiplicand at acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_spd <= s_axis_tdata[54] ? '0 : s_axis_tdata[53:39];
        end
    end

    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MUL1 || r_state == ST_MUL2))
        else $error("multiplier finished outside a multiply state");

    a_no_side_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_side_st.side == SIDE_NONE) |-> (r_side_st.streak == '0 && !r_side_st.releasing))
        else $error("streak or release pending with no locked side");

    a_release_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_side_st.releasing |-> (r_side_st.streak != '0))
        else $error("release set without a confirmation streak");

    a_fin_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> (r_ovalid && r_state == ST_IDLE && r_odata[21:0] == r_offset))
        else $error("final stage did not present the updated offset");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIDE) |-> ((r_mag <= r_max) && ({1'b0, r_spd} != 16'hFFFF)))
        else $error("target magnitude above the configured maximum");

endmodule

>>> sv/loh_mul.sv
module loh_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [loh_pkg::MUL_A_W-1:0] i_a,
    input  logic [loh_pkg::MUL_B_W-1:0]        i_b,
    output logic                               o_done,
    output logic signed [loh_pkg::MUL_P_W-1:0] o_prod
);
    import loh_pkg::*;

    localparam int CNT_BITS = $clog2(MUL_B_W + 1);

    logic signed [MUL_A_W:0]   r_hi, w_sum;
    logic [MUL_B_W-1:0]        r_lo;
    logic signed [MUL_A_W-1:0] r_a;
    logic [CNT_BITS-1:0]       r_cnt;
    logic                      r_busy, r_done;

    // add the multiplicand when the current multiplier bit is set
    assign w_sum = r_hi + (r_lo[0] ? {r_a[MUL_A_W-1], r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_lo <= i_b;
            r_hi <= '0;
        end else if (r_busy) begin
            r_hi <= w_sum >>> 1;
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(MUL_P_W'({r_hi, r_lo}));

endmodule

>>> sv/loh_side.sv
module loh_side (
    input  loh_pkg::t_side_in                  i_in,
    input  loh_pkg::t_side_st                  i_st,
    output loh_pkg::t_side_st                  o_st,
    output logic signed [loh_pkg::OFS_W-1:0]   o_target
);
    import loh_pkg::*;

    logic                    w_lock, w_rel;
    t_side                   w_side;
    logic [CONF_W-1:0]       w_streak;
    logic signed [OFS_W-1:0] w_mag;

    assign w_mag  = $signed({1'b0, i_in.mag});
    assign w_lock = (i_in.offset >= OFS_W'(LOCK_LSB)) || (i_in.offset <= -OFS_W'(LOCK_LSB));

    always_comb begin
        o_st     = i_st;
        o_target = '0;
        w_side   = i_st.side;
        w_rel    = 1'b0;
        w_streak = i_st.streak;
        if (i_in.mag != '0) begin
            if (i_in.center >= i_in.trig) begin
                if (i_st.side == SIDE_NONE) begin
                    if (w_lock) begin
                        w_side = (i_in.offset > 0) ? SIDE_LEFT : SIDE_RIGHT;
                    end else begin
                        w_side = (i_in.left <= i_in.right) ? SIDE_LEFT : SIDE_RIGHT;
                    end
                end
                o_st.side      = w_side;
                o_st.streak    = '0;
                o_st.releasing = 1'b0;
            end else if (i_st.side == SIDE_NONE) begin
                o_st.streak    = '0;
                o_st.releasing = 1'b0;
            end else if (!i_st.releasing) begin
                if (i_in.center <= {1'b0, i_in.rel}) begin
                    if (i_st.streak != STREAK_MAX) begin
                        w_streak = i_st.streak + 1'b1;
                    end
                    if (w_streak >= i_in.confirm) begin
                        o_st.releasing = 1'b1;
                        w_rel          = 1'b1;
                    end
                    o_st.streak = w_streak;
                end else begin
                    o_st.streak = '0;
                end
                if (w_rel) begin
                    w_side = SIDE_NONE;
                end
            end else begin
                w_side = SIDE_NONE;
            end
            unique case (w_side)
                SIDE_LEFT:  o_target = w_mag;
                SIDE_RIGHT: o_target = -w_mag;
                default:    o_target = '0;
            endcase
        end
    end

endmodule
